/* hdl/sseg_pkg.sv */
// Shared types, codes and character classes for the sentence segmenter.
`timescale 1ns / 1ps

package sseg_pkg;

  localparam int CP_W       = 21;
  localparam int REQ_W      = 2;
  localparam int LEN_W      = 6;
  localparam int SKIP_W     = 8;
  localparam int CMP_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [REQ_W-1:0] REQ_FEED    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FLUSH   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_MARKS      = 3'd3;

  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST       = 6'd63;
  localparam logic [LEN_W-1:0]  MIN_LENGTH_RST       = 6'd6;
  localparam logic [LEN_W-1:0]  MIN_LENGTH_FIRST_RST = 6'd4;
  localparam logic [SKIP_W-1:0] SKIP_MARKS_RST       = 8'd0;

  localparam logic [CP_W-1:0] CH_TAB   = 21'h00009;
  localparam logic [CP_W-1:0] CH_LF    = 21'h0000A;
  localparam logic [CP_W-1:0] CH_CR    = 21'h0000D;
  localparam logic [CP_W-1:0] CH_SPACE = 21'h00020;
  localparam logic [CP_W-1:0] CH_COMMA = 21'h0002C;
  localparam logic [CP_W-1:0] CH_SLASH = 21'h0002F;
  localparam logic [CP_W-1:0] CH_LT    = 21'h0003C;
  localparam logic [CP_W-1:0] CH_GT    = 21'h0003E;
  localparam logic [CP_W-1:0] CH_T     = 21'h00074;
  localparam logic [CP_W-1:0] CH_H     = 21'h00068;
  localparam logic [CP_W-1:0] CH_I     = 21'h00069;
  localparam logic [CP_W-1:0] CH_N     = 21'h0006E;
  localparam logic [CP_W-1:0] CH_K     = 21'h0006B;
  localparam logic [CP_W-1:0] CH_IDEO_STOP  = 21'h03002;
  localparam logic [CP_W-1:0] CH_IDEO_COMMA = 21'h03001;
  localparam logic [CP_W-1:0] CH_FW_EXCL    = 21'h0FF01;
  localparam logic [CP_W-1:0] CH_FW_QUEST   = 21'h0FF1F;
  localparam logic [CP_W-1:0] CH_FW_SEMI    = 21'h0FF1B;
  localparam logic [CP_W-1:0] CH_FW_COMMA   = 21'h0FF0C;
  localparam logic [CP_W-1:0] CH_FW_COLON   = 21'h0FF1A;

  localparam logic [2:0] OPEN_TAG_LEN  = 3'd7;
  localparam logic [3:0] CLOSE_TAG_LEN = 4'd8;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CP_W-1:0]  code_point;
    logic             close_stream;
  } sseg_in_t;

  typedef struct packed {
    logic [CP_W-1:0] out_char;
    logic            sentence_last;
    logic            end_of_stream;
  } sseg_out_t;

  typedef struct packed {
    logic feed;
    logic clear;
    logic restart;
    logic inc_skip;
    logic set_first;
    logic ld_ptr;
    logic inc_ptr;
    logic rd;
    logic load_char;
    logic load_end;
  } sseg_cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic ge_limit;
    logic strong_mark;
    logic weak_mark;
    logic ge_min;
    logic skip_pending;
    logic len_ok;
    logic empty;
    logic ptr_last;
    logic out_free;
  } sseg_stat_t;

  function automatic logic is_blank(input logic [CP_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_strong(input logic [CP_W-1:0] c);
    return (c == CH_IDEO_STOP) || (c == CH_FW_EXCL) || (c == CH_FW_QUEST) ||
           (c == CH_FW_SEMI) || (c == CH_LF);
  endfunction

  function automatic logic is_weak(input logic [CP_W-1:0] c);
    return (c == CH_FW_COMMA) || (c == CH_IDEO_COMMA) || (c == CH_FW_COLON) ||
           (c == CH_COMMA);
  endfunction

  function automatic logic [CP_W-1:0] open_pat(input logic [2:0] idx);
    logic [CP_W-1:0] ch;
    case (idx)
      3'd0:    ch = CH_LT;
      3'd1:    ch = CH_T;
      3'd2:    ch = CH_H;
      3'd3:    ch = CH_I;
      3'd4:    ch = CH_N;
      3'd5:    ch = CH_K;
      default: ch = CH_GT;
    endcase
    return ch;
  endfunction

  function automatic logic [CP_W-1:0] close_pat(input logic [3:0] idx);
    logic [CP_W-1:0] ch;
    case (idx)
      4'd0:    ch = CH_LT;
      4'd1:    ch = CH_SLASH;
      4'd2:    ch = CH_T;
      4'd3:    ch = CH_H;
      4'd4:    ch = CH_I;
      4'd5:    ch = CH_N;
      4'd6:    ch = CH_K;
      default: ch = CH_GT;
    endcase
    return ch;
  endfunction

endpackage

/* hdl/streaming_sentence_segmenter.sv */
// Top level of the streaming sentence segmenter.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in_     | input     | in_valid / in_stall | sseg_in_t  (req_type, code_point,
//           |           |                     |   close_stream)
//   out_    | output    | out_valid/out_stall | sseg_out_t (out_char,
//           |           |                     |   sentence_last, end_of_stream)
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// A feed without emission passes the evaluation state, a restart stays in idle.
// An emission does a store read, then an output register load, per character;
// a closing flush adds an end marker; one request is in flight at a time.
// Reset is synchronous; no clearing pass, the store is tracked by its fill count.
// out_stall holds the load of the next character; the last transaction of a
// request may still wait in the output register while the next request enters.
`timescale 1ns / 1ps

module streaming_sentence_segmenter #(
  parameter int BUFFER_DEPTH = 63
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sseg_pkg::sseg_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sseg_pkg::sseg_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sseg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sseg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sseg_pkg::sseg_cmd_t  cmd;
  sseg_pkg::sseg_stat_t stat;

  assign cfg_ready = 1'b1;

  sseg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sseg_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .code_point (in_data.code_point),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

/* hdl/sseg_ctrl.sv */
// Segmenter controller: request decode, emission decision and streaming sequence.
`timescale 1ns / 1ps

module sseg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  sseg_pkg::sseg_in_t  in_data,
  output logic                in_stall,
  input  sseg_pkg::sseg_stat_t stat,
  output sseg_pkg::sseg_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LD   = 3'd3;
  localparam logic [2:0] S_ENDM = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       flush_r, flush_nxt;
  logic       fend_r, fend_nxt;
  logic       frc;
  logic       trig;
  logic [2:0] after_state;

  assign in_stall    = (state_r != S_IDLE);
  assign after_state = (flush_r && fend_r) ? S_ENDM : S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    flush_nxt = flush_r;
    fend_nxt  = fend_r;
    frc       = flush_r || stat.ge_limit;
    trig      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.req_type)
            sseg_pkg::REQ_FEED: begin
              cmd.feed  = 1'b1;
              flush_nxt = 1'b0;
              fend_nxt  = 1'b0;
              state_nxt = S_EVAL;
            end
            sseg_pkg::REQ_FLUSH: begin
              flush_nxt = 1'b1;
              fend_nxt  = in_data.close_stream;
              state_nxt = S_EVAL;
            end
            sseg_pkg::REQ_RESTART: begin
              cmd.clear   = 1'b1;
              cmd.restart = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_EVAL: begin
        if (frc) begin
          trig = 1'b1;
        end else if (stat.strong_mark || (stat.weak_mark && stat.ge_min)) begin
          if (stat.skip_pending) begin
            cmd.inc_skip = 1'b1;
          end else begin
            trig = 1'b1;
          end
        end
        state_nxt = after_state;
        if (trig && !stat.fill_zero && (frc || stat.len_ok)) begin
          if (stat.empty) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.ld_ptr = 1'b1;
            state_nxt  = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        if (stat.out_free) begin
          cmd.load_char = 1'b1;
          cmd.inc_ptr   = 1'b1;
          if (stat.ptr_last) begin
            cmd.set_first = 1'b1;
            cmd.clear     = 1'b1;
            state_nxt     = after_state;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_ENDM: begin
        if (stat.out_free) begin
          cmd.load_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flush_r <= 1'b0;
      fend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
      fend_r  <= fend_nxt;
    end
  end

endmodule

/* hdl/sseg_dp.sv */
// Segmenter datapath: config registers, character store, trim and tag tracking, output register.
`timescale 1ns / 1ps

module sseg_dp #(
  parameter int BUFFER_DEPTH = 63
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [sseg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sseg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [sseg_pkg::CP_W-1:0]           code_point,
  input  sseg_pkg::sseg_cmd_t                 cmd,
  output sseg_pkg::sseg_stat_t                stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sseg_pkg::sseg_out_t                 out_data
);

  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int CP_W   = sseg_pkg::CP_W;
  localparam int CMP_W  = sseg_pkg::CMP_W;
  localparam int LEN_W  = sseg_pkg::LEN_W;
  localparam int SKIP_W = sseg_pkg::SKIP_W;

  logic [LEN_W-1:0]  max_len_r, min_len_r, min_first_r;
  logic [SKIP_W-1:0] skip_lim_r, skipped_r;
  logic              first_done_r;

  logic [CP_W-1:0]   mem [BUFFER_DEPTH];
  logic [CP_W-1:0]   rd_data_r;

  logic [CNT_W-1:0]  fill_r;
  logic [ADDR_W-1:0] first_pos_r, last_pos_r, ptr_r;
  logic              has_r;
  logic [2:0]        open_r;
  logic [3:0]        close_r;
  logic              tag_r;
  logic              strong_r, weak_r;

  logic [3:0]        open_nxt;
  logic [4:0]        close_nxt;
  logic              open_hit, close_hit;

  logic              out_valid_r;
  sseg_pkg::sseg_out_t out_data_r;

  logic [CMP_W-1:0]  fill_ext, min_req, len;
  logic [ADDR_W-1:0] wr_addr;

  assign wr_addr  = fill_r[ADDR_W-1:0];
  assign fill_ext = CMP_W'(fill_r);
  assign min_req  = CMP_W'(first_done_r ? min_len_r : min_first_r);
  assign len      = has_r ? (CMP_W'(last_pos_r) - CMP_W'(first_pos_r) + CMP_W'(1)) : '0;

  always_comb begin
    if ((open_r < sseg_pkg::OPEN_TAG_LEN) && (code_point == sseg_pkg::open_pat(open_r))) begin
      open_nxt = {1'b0, open_r} + 4'd1;
    end else begin
      open_nxt = (code_point == sseg_pkg::CH_LT) ? 4'd1 : 4'd0;
    end
    if ((close_r < sseg_pkg::CLOSE_TAG_LEN) &&
        (code_point == sseg_pkg::close_pat(close_r))) begin
      close_nxt = {1'b0, close_r} + 5'd1;
    end else begin
      close_nxt = (code_point == sseg_pkg::CH_LT) ? 5'd1 : 5'd0;
    end
    open_hit  = (open_nxt == {1'b0, sseg_pkg::OPEN_TAG_LEN});
    close_hit = (close_nxt == {1'b0, sseg_pkg::CLOSE_TAG_LEN});
  end

  always_comb begin
    stat.fill_zero    = (fill_r == '0);
    stat.ge_limit     = (fill_ext >= CMP_W'(max_len_r)) ||
                        (fill_r >= CNT_W'(BUFFER_DEPTH));
    stat.strong_mark  = strong_r;
    stat.weak_mark    = weak_r;
    stat.ge_min       = (fill_ext >= min_req);
    stat.skip_pending = (skipped_r < skip_lim_r);
    stat.len_ok       = (len >= min_req);
    stat.empty        = (len == '0) || tag_r;
    stat.ptr_last     = (ptr_r == last_pos_r);
    stat.out_free     = !out_valid_r || !out_stall;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= sseg_pkg::MAX_LENGTH_RST;
      min_len_r   <= sseg_pkg::MIN_LENGTH_RST;
      min_first_r <= sseg_pkg::MIN_LENGTH_FIRST_RST;
      skip_lim_r  <= sseg_pkg::SKIP_MARKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sseg_pkg::REG_MAX_LENGTH:       max_len_r   <= cfg_wdata[LEN_W-1:0];
        sseg_pkg::REG_MIN_LENGTH:       min_len_r   <= cfg_wdata[LEN_W-1:0];
        sseg_pkg::REG_MIN_LENGTH_FIRST: min_first_r <= cfg_wdata[LEN_W-1:0];
        sseg_pkg::REG_SKIP_MARKS:       skip_lim_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // character store
  always_ff @(posedge clk) begin
    if (cmd.feed) begin
      mem[wr_addr] <= code_point;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  // store bookkeeping and session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      first_pos_r  <= '0;
      last_pos_r   <= '0;
      has_r        <= 1'b0;
      open_r       <= '0;
      close_r      <= '0;
      tag_r        <= 1'b0;
      strong_r     <= 1'b0;
      weak_r       <= 1'b0;
      skipped_r    <= '0;
      first_done_r <= 1'b0;
      ptr_r        <= '0;
    end else begin
      if (cmd.feed) begin
        fill_r   <= fill_r + CNT_W'(1);
        strong_r <= sseg_pkg::is_strong(code_point);
        weak_r   <= sseg_pkg::is_weak(code_point);
        if (!sseg_pkg::is_blank(code_point)) begin
          if (!has_r) begin
            first_pos_r <= wr_addr;
          end
          last_pos_r <= wr_addr;
          has_r      <= 1'b1;
        end
        open_r  <= open_hit ? 3'd0 : open_nxt[2:0];
        close_r <= close_hit ? 4'd0 : close_nxt[3:0];
        if (open_hit || close_hit) begin
          tag_r <= 1'b1;
        end
      end
      if (cmd.clear) begin
        fill_r      <= '0;
        first_pos_r <= '0;
        last_pos_r  <= '0;
        has_r       <= 1'b0;
        open_r      <= '0;
        close_r     <= '0;
        tag_r       <= 1'b0;
      end
      if (cmd.inc_skip) begin
        skipped_r <= skipped_r + SKIP_W'(1);
      end
      if (cmd.set_first) begin
        first_done_r <= 1'b1;
      end
      if (cmd.restart) begin
        skipped_r    <= '0;
        first_done_r <= 1'b0;
      end
      if (cmd.ld_ptr) begin
        ptr_r <= first_pos_r;
      end else if (cmd.inc_ptr) begin
        ptr_r <= ptr_r + ADDR_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_char || cmd.load_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      out_data_r.out_char      <= rd_data_r;
      out_data_r.sentence_last <= (ptr_r == last_pos_r);
      out_data_r.end_of_stream <= 1'b0;
    end else if (cmd.load_end) begin
      out_data_r.out_char      <= '0;
      out_data_r.sentence_last <= 1'b1;
      out_data_r.end_of_stream <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_char || cmd.load_end) |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while a transaction is pending");
  a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
    has_r |-> (first_pos_r <= last_pos_r))
    else $error("content positions out of order");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.feed |-> (fill_r < CNT_W'(BUFFER_DEPTH)))
    else $error("feed into a full store");
  a_rd_content: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (has_r && !tag_r))
    else $error("store read without content to stream");
`endif

endmodule

/* sim/sseg_checker.sv */
// Sentence segmenter checker: tracks the channels, predicts output transactions, compares.
`timescale 1ns / 1ps

module sseg_checker #(
  parameter int DEPTH = 63
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  sseg_pkg::sseg_in_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  sseg_pkg::sseg_out_t                 out_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [sseg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sseg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                  fail_cnt,
  output int                                  pending_cnt
);

  localparam int CP_W       = sseg_pkg::CP_W;
  localparam int LEN_W      = sseg_pkg::LEN_W;
  localparam int SKIP_W     = sseg_pkg::SKIP_W;
  localparam int CFG_IDX_W  = sseg_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = sseg_pkg::CFG_DATA_W;

  logic [CP_W-1:0] text_buf [DEPTH];
  int fill;
  int head;
  int tail;
  bit has_text;
  int marks_skipped;
  bit first_done;
  int open_prog;
  int close_prog;
  bit tag_hit;

  int max_len;
  int min_len;
  int min_first;
  int skip_lim;

  sseg_pkg::sseg_out_t sentence_q[$];
  int errs;

  function automatic bit blank_ch(input logic [CP_W-1:0] c);
    return c == sseg_pkg::CH_SPACE || c == sseg_pkg::CH_TAB || c == sseg_pkg::CH_CR ||
           c == sseg_pkg::CH_LF;
  endfunction

  function automatic bit strong_ch(input logic [CP_W-1:0] c);
    return c == sseg_pkg::CH_IDEO_STOP || c == sseg_pkg::CH_FW_EXCL ||
           c == sseg_pkg::CH_FW_QUEST || c == sseg_pkg::CH_FW_SEMI || c == sseg_pkg::CH_LF;
  endfunction

  function automatic bit weak_ch(input logic [CP_W-1:0] c);
    return c == sseg_pkg::CH_FW_COMMA || c == sseg_pkg::CH_IDEO_COMMA ||
           c == sseg_pkg::CH_FW_COLON || c == sseg_pkg::CH_COMMA;
  endfunction

  // "<think>" when closing is 0, "</think>" otherwise
  function automatic logic [CP_W-1:0] tag_ch(input bit closing, input int idx);
    logic [CP_W-1:0] c;
    int k;
    k = closing ? idx : ((idx == 0) ? 0 : idx + 1);
    case (k)
      0:       c = sseg_pkg::CH_LT;
      1:       c = sseg_pkg::CH_SLASH;
      2:       c = sseg_pkg::CH_T;
      3:       c = sseg_pkg::CH_H;
      4:       c = sseg_pkg::CH_I;
      5:       c = sseg_pkg::CH_N;
      6:       c = sseg_pkg::CH_K;
      default: c = sseg_pkg::CH_GT;
    endcase
    return c;
  endfunction

  function automatic void clear_sentence();
    fill       = 0;
    head       = 0;
    tail       = 0;
    has_text   = 1'b0;
    open_prog  = 0;
    close_prog = 0;
    tag_hit    = 1'b0;
  endfunction

  function automatic void advance_tags(input logic [CP_W-1:0] c);
    if (open_prog < 7 && c == tag_ch(1'b0, open_prog)) open_prog++;
    else open_prog = (c == sseg_pkg::CH_LT) ? 1 : 0;
    if (open_prog >= 7) begin
      tag_hit   = 1'b1;
      open_prog = 0;
    end
    if (close_prog < 8 && c == tag_ch(1'b1, close_prog)) close_prog++;
    else close_prog = (c == sseg_pkg::CH_LT) ? 1 : 0;
    if (close_prog >= 8) begin
      tag_hit    = 1'b1;
      close_prog = 0;
    end
  endfunction

  function automatic int needed_len();
    return first_done ? min_len : min_first;
  endfunction

  function automatic void emit_sentence(input bit forced);
    int len;
    int i;
    sseg_pkg::sseg_out_t r;
    if (fill == 0) return;
    len = has_text ? tail - head + 1 : 0;
    if (!forced && len < needed_len()) return;
    if (len == 0 || tag_hit) begin
      clear_sentence();
      return;
    end
    for (i = head; i <= tail && i < DEPTH; i++) begin
      r.out_char      = text_buf[i];
      r.sentence_last = (i == tail);
      r.end_of_stream = 1'b0;
      sentence_q.push_back(r);
    end
    first_done = 1'b1;
    clear_sentence();
  endfunction

  function automatic void take_mark();
    if (marks_skipped < skip_lim) marks_skipped++;
    else emit_sentence(1'b0);
  endfunction

  function automatic void segment_request(input sseg_pkg::sseg_in_t req);
    logic [CP_W-1:0] c;
    int limit;
    sseg_pkg::sseg_out_t r;
    c = req.code_point;
    case (req.req_type)
      sseg_pkg::REQ_FEED: begin
        if (fill >= DEPTH) clear_sentence();
        text_buf[fill] = c;
        if (!blank_ch(c)) begin
          if (!has_text) head = fill;
          tail     = fill;
          has_text = 1'b1;
        end
        advance_tags(c);
        fill++;
        limit = (max_len < DEPTH) ? max_len : DEPTH;
        if (fill >= limit) emit_sentence(1'b1);
        else if (strong_ch(c)) take_mark();
        else if (weak_ch(c) && fill >= needed_len()) take_mark();
      end
      sseg_pkg::REQ_FLUSH: begin
        emit_sentence(1'b1);
        if (req.close_stream) begin
          r.out_char      = '0;
          r.sentence_last = 1'b1;
          r.end_of_stream = 1'b1;
          sentence_q.push_back(r);
        end
      end
      sseg_pkg::REQ_RESTART: begin
        clear_sentence();
        marks_skipped = 0;
        first_done    = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      sseg_pkg::REG_MAX_LENGTH:       max_len   = int'(val[LEN_W-1:0]);
      sseg_pkg::REG_MIN_LENGTH:       min_len   = int'(val[LEN_W-1:0]);
      sseg_pkg::REG_MIN_LENGTH_FIRST: min_first = int'(val[LEN_W-1:0]);
      sseg_pkg::REG_SKIP_MARKS:       skip_lim  = int'(val[SKIP_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic void check_char(input sseg_pkg::sseg_out_t got);
    sseg_pkg::sseg_out_t want;
    if (sentence_q.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("%0t: unexpected transaction: char %h last %b eos %b", $time,
                 got.out_char, got.sentence_last, got.end_of_stream);
      return;
    end
    want = sentence_q.pop_front();
    if (got.out_char !== want.out_char || got.sentence_last !== want.sentence_last ||
        got.end_of_stream !== want.end_of_stream) begin
      errs++;
      if (errs <= 10)
        $display("%0t: mismatch: expected char %h last %b eos %b, got char %h last %b eos %b",
                 $time, want.out_char, want.sentence_last, want.end_of_stream,
                 got.out_char, got.sentence_last, got.end_of_stream);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      max_len       = int'(sseg_pkg::MAX_LENGTH_RST);
      min_len       = int'(sseg_pkg::MIN_LENGTH_RST);
      min_first     = int'(sseg_pkg::MIN_LENGTH_FIRST_RST);
      skip_lim      = int'(sseg_pkg::SKIP_MARKS_RST);
      marks_skipped = 0;
      first_done    = 1'b0;
      errs          = 0;
      clear_sentence();
      sentence_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_wdata);
      if (out_valid && !out_stall) check_char(out_data);
      if (in_valid && !in_stall) segment_request(in_data);
    end
    fail_cnt    <= errs;
    pending_cnt <= sentence_q.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the sentence segmenter: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int CP_W       = sseg_pkg::CP_W;
  localparam int REQ_W      = sseg_pkg::REQ_W;
  localparam int CFG_IDX_W  = sseg_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = sseg_pkg::CFG_DATA_W;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 12;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  sseg_pkg::sseg_in_t    in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  sseg_pkg::sseg_out_t   out_data;
  logic                  cfg_ready;
  int                    fail_cnt;
  int                    pending_cnt;

  int send_idle = 0;
  int stall_idle = 0;
  int quiet = 0;

  streaming_sentence_segmenter #(.BUFFER_DEPTH(63)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sseg_checker #(.DEPTH(63)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= (stall_idle > 0) && ($urandom_range(99) < stall_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send_item(input sseg_pkg::sseg_in_t req);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed(input logic [CP_W-1:0] cp);
    sseg_pkg::sseg_in_t req;
    req.req_type     = sseg_pkg::REQ_FEED;
    req.code_point   = cp;
    req.close_stream = 1'($urandom_range(1));
    send_item(req);
  endtask

  task automatic request(input logic [REQ_W-1:0] kind, input logic fend);
    sseg_pkg::sseg_in_t req;
    req.req_type     = kind;
    req.code_point   = CP_W'($urandom_range(21'h1FFFFF));
    req.close_stream = fend;
    send_item(req);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input int max_len, input int min_len, input int min_first,
                           input int skip);
    cfg_write(sseg_pkg::REG_MAX_LENGTH, max_len);
    cfg_write(sseg_pkg::REG_MIN_LENGTH, min_len);
    cfg_write(sseg_pkg::REG_MIN_LENGTH_FIRST, min_first);
    cfg_write(sseg_pkg::REG_SKIP_MARKS, skip);
    cfg_valid <= 1'b0;
  endtask

  // wait until all predicted output has arrived, then give the block a drain period
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CP_W-1:0] pick_text();
    logic [CP_W-1:0] c;
    case ($urandom_range(11))
      0, 1, 2, 3: c = CP_W'(21'h61 + $urandom_range(25));
      4, 5:       c = CP_W'(21'h4E00 + $urandom_range(16'h51FF));
      6:          c = sseg_pkg::CH_SPACE;
      7:          c = ($urandom_range(1) == 0) ? sseg_pkg::CH_TAB : sseg_pkg::CH_CR;
      8:          c = CP_W'($urandom_range(21'h1FFFFF));
      9:          c = sseg_pkg::open_pat(3'($urandom_range(6)));
      10:         c = ($urandom_range(1) == 0) ? 21'h1FFFFF : 21'h0;
      default:    c = sseg_pkg::CH_COMMA;
    endcase
    return c;
  endfunction

  function automatic logic [CP_W-1:0] pick_mark();
    logic [CP_W-1:0] c;
    case ($urandom_range(8))
      0:       c = sseg_pkg::CH_IDEO_STOP;
      1:       c = sseg_pkg::CH_FW_EXCL;
      2:       c = sseg_pkg::CH_FW_QUEST;
      3:       c = sseg_pkg::CH_FW_SEMI;
      4:       c = sseg_pkg::CH_LF;
      5:       c = sseg_pkg::CH_FW_COMMA;
      6:       c = sseg_pkg::CH_IDEO_COMMA;
      7:       c = sseg_pkg::CH_FW_COLON;
      default: c = sseg_pkg::CH_COMMA;
    endcase
    return c;
  endfunction

  task automatic directed_items();
    int k;
    feed(sseg_pkg::CH_SPACE);
    feed(21'h1FFFFF);
    feed(sseg_pkg::CH_FW_SEMI);
    feed(21'h0);
    feed(sseg_pkg::CH_IDEO_COMMA);
    feed(sseg_pkg::CH_TAB);
    for (k = 0; k < 7; k++) feed(sseg_pkg::open_pat(3'(k)));
    feed(sseg_pkg::CH_IDEO_STOP);
    for (k = 0; k < 8; k++) feed(sseg_pkg::close_pat(4'(k)));
    request(sseg_pkg::REQ_FLUSH, 1'b1);
    request(sseg_pkg::REQ_FLUSH, 1'b0);
    request(REQ_NONE, 1'b1);
    feed(sseg_pkg::CH_CR);
    feed(sseg_pkg::CH_FW_EXCL);
    request(sseg_pkg::REQ_FLUSH, 1'b1);
    request(sseg_pkg::REQ_RESTART, 1'b0);
  endtask

  task automatic random_items(input int count);
    int sent;
    int r;
    int n;
    int k;
    bit closing;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 60) begin
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) feed(pick_text());
        if ($urandom_range(3) != 0) begin
          feed(pick_mark());
          n++;
        end
        sent += n;
      end else if (r < 72) begin
        closing = 1'($urandom_range(1));
        n = closing ? 8 : 7;
        if ($urandom_range(2) == 0) n = $urandom_range(1, n - 1);
        for (k = 0; k < n; k++)
          feed(closing ? sseg_pkg::close_pat(4'(k)) : sseg_pkg::open_pat(3'(k)));
        feed(pick_mark());
        sent += n + 1;
      end else if (r < 82) begin
        request(sseg_pkg::REQ_FLUSH, 1'($urandom_range(1)));
        sent++;
      end else if (r < 86) begin
        request(sseg_pkg::REQ_RESTART, 1'($urandom_range(1)));
        sent++;
      end else if (r < 88) begin
        request(REQ_NONE, 1'($urandom_range(1)));
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) feed(CP_W'($urandom_range(21'h1FFFFF)));
        sent += n;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();

    settle();
    configure(8, 0, 0, 3);
    random_items(80);

    settle();
    send_idle = 78;
    configure(0, 63, 63, 0);
    random_items(60);

    settle();
    send_idle  = 0;
    stall_idle = 78;
    configure(63, 63, 0, 255);
    random_items(80);

    settle();
    send_idle  = 38;
    stall_idle = 38;
    configure(20, 3, 10, 1);
    random_items(80);

    settle();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
